// File: rtl/core/arb_pkg.sv
package arb_pkg;

  // Field widths of the request and result records
  localparam int OP_W         = 2;
  localparam int COLOR_W      = 32;
  localparam int PAYLOAD_W    = 64;
  localparam int LIFE_W       = 16;
  localparam int IDX_FIELD_W  = 9;
  localparam int FADE_W       = 16;

  // Alpha sits in the top byte of an ARGB word
  localparam int ALPHA_LSB    = 24;
  localparam int ALPHA_W      = 8;

  localparam logic [FADE_W-1:0] FADE_RESET = 16'd500;

  // floor(p / 1000) for any 32-bit p: (p * DIV_MAGIC) >> DIV_SHIFT, exact
  localparam int PROD_W       = 32;
  localparam int MAGIC_W      = 29;
  localparam logic [MAGIC_W-1:0] DIV_MAGIC = 29'd274877907;
  localparam int DIV_SHIFT    = 38;
  localparam int RECIP_W      = PROD_W + MAGIC_W;
  localparam int DALPHA_W     = RECIP_W - DIV_SHIFT;

  typedef logic [IDX_FIELD_W-1:0] cnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_WALK,
    ST_READ
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]        operation;
    logic [COLOR_W-1:0]     particle_color;
    logic [PAYLOAD_W-1:0]   particle_payload;
    logic [LIFE_W-1:0]      lifetime_ms;
    logic [LIFE_W-1:0]      elapsed_ms;
    logic [IDX_FIELD_W-1:0] read_index;
  } request_t;

  typedef struct packed {
    logic                   accepted;
    logic [IDX_FIELD_W-1:0] retired_count;
    logic [IDX_FIELD_W-1:0] occupancy;
    logic                   entry_in_window;
    logic [COLOR_W-1:0]     entry_color;
    logic [PAYLOAD_W-1:0]   entry_payload;
    logic [LIFE_W-1:0]      entry_life_ms;
  } result_t;

endpackage

// File: rtl/core/aging_ring_buffer_with_fade.sv
// Channel   | Signals                       | Direction | Handshake
// ----------+-------------------------------+-----------+-------------------------------
// request   | start, busy, req_i            | in        | taken when start & !busy
// result    | res_valid_o, res_o            | out       | one-cycle strobe, no back-pressure
// config    | cfg_we_i, cfg_wdata_i         | in        | fade_rate written when cfg_we_i
//
// Flow: add and no-op requests leave the block idle; the result is registered and shows in the
//   next cycle, and a new request is taken in that same cycle. A read issues one RAM read and
//   forms its result in ST_READ. A tick runs the fade scaling multiplies (on accept and in
//   ST_SCALE), then one pass over the live entries through the single read port of the state RAM.
// Reset clears head, tail, fade_rate (to 500) and control; the RAMs need no clearing.
// The receiver cannot stall: each result is presented for exactly one cycle.
module aging_ring_buffer_with_fade #(
  parameter int SLOTS = 512
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  arb_pkg::request_t             req_i,
  input  logic                          cfg_we_i,
  input  logic [arb_pkg::FADE_W-1:0]    cfg_wdata_i,
  output logic                          res_valid_o,
  output arb_pkg::result_t              res_o
);

  localparam int IdxW = $clog2(SLOTS);
  localparam int RdW  = ((IdxW > arb_pkg::IDX_FIELD_W) ? IdxW : arb_pkg::IDX_FIELD_W) + 1;
  localparam int StW  = arb_pkg::COLOR_W + arb_pkg::LIFE_W;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [IdxW:0]   ext_t;
  typedef logic [RdW-1:0]  rd_t;
  typedef logic [StW-1:0]  word_t;

  localparam idx_t LastSlot = idx_t'(SLOTS - 1);
  localparam ext_t SlotsE   = ext_t'(SLOTS);
  localparam rd_t  SlotsR   = rd_t'(SLOTS);

  function automatic idx_t next_slot(idx_t i);
    return (i == LastSlot) ? '0 : i + idx_t'(1);
  endfunction

  // Live entries between tail and head, modulo the ring size
  function automatic idx_t occ_of(idx_t h, idx_t t);
    ext_t diff;
    diff = {1'b0, h} - {1'b0, t};
    if (h < t) begin
      diff = diff + SlotsE;
    end
    return idx_t'(diff);
  endfunction

  arb_pkg::state_e state_q, state_d;
  idx_t  head_q, head_d;
  idx_t  tail_q, tail_d;
  idx_t  rd_ptr_q, rd_ptr_d;
  idx_t  b_addr_q, b_addr_d;
  idx_t  retired_q, retired_d;
  logic  b_valid_q, b_valid_d;
  logic  retiring_q, retiring_d;
  logic  read_win_q, read_win_d;
  logic  res_valid_q, res_valid_d;
  arb_pkg::result_t res_q, res_d;

  logic [arb_pkg::FADE_W-1:0]  fade_q;
  logic [arb_pkg::LIFE_W-1:0]  elapsed_q;
  logic [arb_pkg::PROD_W-1:0]  prod_q;
  logic [arb_pkg::RECIP_W-1:0] recip_q;
  logic [arb_pkg::DALPHA_W-1:0] dalpha;

  logic accept;
  rd_t  ridx_ext;
  idx_t rslot;
  logic in_range, in_win;

  // State RAM holds {color, life}; payload RAM is touched only by add and read
  logic  st_we;
  idx_t  st_waddr, st_raddr;
  word_t st_wdata, st_rdata;
  logic  pl_we;
  logic [arb_pkg::PAYLOAD_W-1:0] pl_rdata;

  logic [arb_pkg::COLOR_W-1:0] old_color;
  logic [arb_pkg::LIFE_W-1:0]  old_life, new_life;
  logic [arb_pkg::ALPHA_W-1:0] old_alpha, new_alpha;

  arb_ram #(.WIDTH(StW), .DEPTH(SLOTS)) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  arb_ram #(.WIDTH(arb_pkg::PAYLOAD_W), .DEPTH(SLOTS)) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (pl_we),
    .waddr_i (head_q),
    .wdata_i (req_i.particle_payload),
    .raddr_i (rslot),
    .rdata_o (pl_rdata)
  );

  assign busy   = (state_q != arb_pkg::ST_IDLE);
  assign accept = start & ~busy;

  // Window test for a read request: slot in range and between tail and head
  assign ridx_ext = rd_t'(req_i.read_index);
  assign in_range = (ridx_ext < SlotsR);
  assign rslot    = idx_t'(ridx_ext);
  assign in_win   = in_range &&
                    ((head_q >= tail_q) ? (rslot >= tail_q && rslot < head_q)
                                        : (rslot >= tail_q || rslot < head_q));

  // Alpha decrement: elapsed * fade / 1000, truncated
  assign dalpha = recip_q[arb_pkg::DIV_SHIFT +: arb_pkg::DALPHA_W];

  // Age one entry read back from the state RAM
  assign old_life  = st_rdata[arb_pkg::LIFE_W-1:0];
  assign old_color = st_rdata[StW-1 -: arb_pkg::COLOR_W];
  assign old_alpha = old_color[arb_pkg::ALPHA_LSB +: arb_pkg::ALPHA_W];
  assign new_life  = (old_life > elapsed_q) ? old_life - elapsed_q : '0;
  assign new_alpha = ({(arb_pkg::DALPHA_W - arb_pkg::ALPHA_W)'(0), old_alpha} > dalpha)
                     ? old_alpha - dalpha[arb_pkg::ALPHA_W-1:0] : '0;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    rd_ptr_d    = rd_ptr_q;
    b_addr_d    = b_addr_q;
    b_valid_d   = b_valid_q;
    retiring_d  = retiring_q;
    retired_d   = retired_q;
    read_win_d  = read_win_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    st_we       = 1'b0;
    st_waddr    = head_q;
    st_wdata    = {req_i.particle_color, req_i.lifetime_ms};
    st_raddr    = rslot;
    pl_we       = 1'b0;

    case (state_q)
      arb_pkg::ST_IDLE: begin
        if (accept) begin
          case (arb_pkg::op_e'(req_i.operation))
            arb_pkg::OP_ADD: begin
              res_valid_d = 1'b1;
              res_d       = '0;
              // Drop the request when the ring already holds SLOTS-1 entries
              if (next_slot(head_q) != tail_q) begin
                st_we          = 1'b1;
                pl_we          = 1'b1;
                head_d         = next_slot(head_q);
                res_d.accepted = 1'b1;
              end
            end
            arb_pkg::OP_TICK: begin
              state_d    = arb_pkg::ST_SCALE;
              rd_ptr_d   = tail_q;
              b_valid_d  = 1'b0;
              retiring_d = 1'b1;
              retired_d  = '0;
            end
            arb_pkg::OP_READ: begin
              state_d    = arb_pkg::ST_READ;
              read_win_d = in_win;
            end
            default: begin
              res_valid_d = 1'b1;
              res_d       = '0;
            end
          endcase
        end
      end

      arb_pkg::ST_SCALE: begin
        state_d = arb_pkg::ST_WALK;
      end

      arb_pkg::ST_WALK: begin
        // Write back stage: age the entry whose data came out of the RAM
        if (b_valid_q) begin
          if (old_life != '0) begin
            st_we    = 1'b1;
            st_waddr = b_addr_q;
            st_wdata = {new_alpha, old_color[arb_pkg::ALPHA_LSB-1:0], new_life};
          end
          // Retire from the tail while the aged lifetime is zero
          if (retiring_q && new_life == '0) begin
            tail_d    = next_slot(tail_q);
            retired_d = retired_q + idx_t'(1);
          end else begin
            retiring_d = 1'b0;
          end
        end
        // Read stage: issue the next live slot, one per cycle
        if (rd_ptr_q != head_q) begin
          st_raddr  = rd_ptr_q;
          b_valid_d = 1'b1;
          b_addr_d  = rd_ptr_q;
          rd_ptr_d  = next_slot(rd_ptr_q);
        end else begin
          b_valid_d = 1'b0;
          if (!b_valid_q) begin
            state_d             = arb_pkg::ST_IDLE;
            res_valid_d         = 1'b1;
            res_d               = '0;
            res_d.retired_count = arb_pkg::cnt_t'(retired_q);
          end
        end
      end

      arb_pkg::ST_READ: begin
        state_d     = arb_pkg::ST_IDLE;
        res_valid_d = 1'b1;
        res_d       = '0;
        if (read_win_q) begin
          res_d.entry_in_window = 1'b1;
          res_d.entry_color     = old_color;
          res_d.entry_payload   = pl_rdata;
          res_d.entry_life_ms   = old_life;
        end
      end

      default: begin
        state_d = arb_pkg::ST_IDLE;
      end
    endcase

    // Report occupancy as it stands after the request
    if (res_valid_d) begin
      res_d.occupancy = arb_pkg::cnt_t'(occ_of(head_d, tail_d));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= arb_pkg::ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      rd_ptr_q    <= '0;
      b_valid_q   <= 1'b0;
      retiring_q  <= 1'b0;
      retired_q   <= '0;
      read_win_q  <= 1'b0;
      res_valid_q <= 1'b0;
      fade_q      <= arb_pkg::FADE_RESET;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      rd_ptr_q    <= rd_ptr_d;
      b_valid_q   <= b_valid_d;
      retiring_q  <= retiring_d;
      retired_q   <= retired_d;
      read_win_q  <= read_win_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        fade_q <= cfg_wdata_i;
      end
    end
  end

  // Datapath registers: fade scaling runs as two registered multiplies
  always_ff @(posedge clk_i) begin
    b_addr_q <= b_addr_d;
    res_q    <= res_d;
    if (accept && arb_pkg::op_e'(req_i.operation) == arb_pkg::OP_TICK) begin
      elapsed_q <= req_i.elapsed_ms;
      prod_q    <= {16'd0, req_i.elapsed_ms} * {16'd0, fade_q};
    end
    if (state_q == arb_pkg::ST_SCALE) begin
      recip_q <= {{arb_pkg::MAGIC_W{1'b0}}, prod_q} *
                 {{arb_pkg::PROD_W{1'b0}}, arb_pkg::DIV_MAGIC};
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Head moves only on an add taken in idle
  a_head_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != arb_pkg::ST_IDLE) |=> $stable(head_q))
    else $error("head moved during a multi-cycle request");

  // The walk never touches the slot at the head
  a_walk_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> (b_addr_q != head_q && state_q == arb_pkg::ST_WALK))
    else $error("walk stage past the head");

  // Retiring proceeds in order from the tail
  a_retire_tail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && retiring_q) |-> (b_addr_q == tail_q))
    else $error("retire stage out of step with tail");

  // Finishing a tick raises the result strobe
  a_tick_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == arb_pkg::ST_WALK && state_d == arb_pkg::ST_IDLE) |=> res_valid_o)
    else $error("tick finished without a result");

endmodule

// File: rtl/core/arb_ram.sv
module arb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
